### sv/csg_pkg.sv
// Shared types, constants and helpers for the circle span generator.
// Used by csg_front, csg_queue, csg_back and circle_span_generator.
package csg_pkg;

  // Fixed field widths
  localparam int unsigned CENTER_W = 9;
  localparam int unsigned COORD_W  = 11;
  localparam int unsigned COLOR_W  = 24;
  localparam int unsigned ERR_W    = 13;

  // Command codes
  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  // Largest coordinate a span field can carry
  localparam logic signed [COORD_W:0] COORD_MAX = 12'sd1023;

  typedef logic signed [COORD_W-1:0] coord_t;

  // One iteration of the midpoint loop, handed from front to back
  typedef struct packed {
    logic [CENTER_W-1:0] cx;
    logic [CENTER_W-1:0] cy;
    coord_t              x;
    coord_t              y;
    logic [COLOR_W-1:0]  color;
    logic                pair_eq;  // x == y: only two spans
    logic                done;     // final iteration of the circle
  } job_t;

  // Clamp a widened coordinate to the top of the field range
  function automatic coord_t sat_coord(input logic signed [COORD_W:0] v);
    coord_t res;
    if (v > COORD_MAX) begin
      res = COORD_MAX[COORD_W-1:0];
    end else begin
      res = v[COORD_W-1:0];
    end
    return res;
  endfunction

endpackage

### sv/csg_front.sv
// Front end: accepts items, holds the circle state and runs the midpoint
// update. Depends on csg_pkg.
module csg_front #(
  parameter int unsigned MAX_DIM = 512
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          in_command,
  input  logic [csg_pkg::CENTER_W-1:0]  in_center_x,
  input  logic [csg_pkg::CENTER_W-1:0]  in_center_y,
  input  logic signed [csg_pkg::COORD_W-1:0] in_radius,
  input  logic [csg_pkg::COLOR_W-1:0]   in_color,
  output logic                          job_push,
  output csg_pkg::job_t                 job_data
);

  localparam csg_pkg::coord_t MaxR = csg_pkg::COORD_W'(MAX_DIM);

  logic                                active_r, active_nxt;
  csg_pkg::coord_t                     x_r, x_nxt;
  csg_pkg::coord_t                     y_r, y_nxt;
  logic signed [csg_pkg::ERR_W-1:0]    err_r, err_nxt;
  logic [csg_pkg::CENTER_W-1:0]        cx_r, cx_nxt;
  logic [csg_pkg::CENTER_W-1:0]        cy_r, cy_nxt;
  logic [csg_pkg::COLOR_W-1:0]         color_r, color_nxt;

  logic                                accept;
  csg_pkg::coord_t                     r_clamp;
  logic signed [csg_pkg::ERR_W:0]      e1, e2;
  csg_pkg::coord_t                     x_step, y_step;
  logic signed [csg_pkg::ERR_W-1:0]    err_step;

  assign accept = in_valid && !in_stall;

  // Radius clamp for a start item
  always_comb begin
    r_clamp = (in_radius > MaxR) ? MaxR : in_radius;
  end

  // One midpoint iteration from the held state
  always_comb begin
    e1     = {err_r[csg_pkg::ERR_W-1], err_r}
           + {{2{y_r[csg_pkg::COORD_W-1]}}, y_r, 1'b0} + 14'sd1;
    e2     = e1 - {{2{x_r[csg_pkg::COORD_W-1]}}, x_r, 1'b0} + 14'sd1;
    y_step = y_r + 11'sd1;
    if (e1 >= 14'sd0) begin
      x_step   = x_r - 11'sd1;
      err_step = e2[csg_pkg::ERR_W-1:0];
    end else begin
      x_step   = x_r;
      err_step = e1[csg_pkg::ERR_W-1:0];
    end
  end

  // Next state
  always_comb begin
    active_nxt = active_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    err_nxt    = err_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    color_nxt  = color_r;
    job_push   = 1'b0;
    if (accept) begin
      if (in_command == csg_pkg::CMD_START) begin
        cx_nxt     = in_center_x;
        cy_nxt     = in_center_y;
        color_nxt  = in_color;
        x_nxt      = r_clamp;
        y_nxt      = '0;
        err_nxt    = -{{2{r_clamp[csg_pkg::COORD_W-1]}}, r_clamp};
        active_nxt = !r_clamp[csg_pkg::COORD_W-1];
      end else if (active_r) begin
        job_push   = 1'b1;
        x_nxt      = x_step;
        y_nxt      = y_step;
        err_nxt    = err_step;
        active_nxt = !(x_step < y_step);
      end
    end
  end

  // Job for the back end: current offsets, pre-update
  always_comb begin
    job_data.cx      = cx_r;
    job_data.cy      = cy_r;
    job_data.x       = x_r;
    job_data.y       = y_r;
    job_data.color   = color_r;
    job_data.pair_eq = (x_r == y_r);
    job_data.done    = (x_step < y_step);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      x_r      <= '0;
      y_r      <= '0;
      err_r    <= '0;
      cx_r     <= '0;
      cy_r     <= '0;
      color_r  <= '0;
    end else begin
      active_r <= active_nxt;
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      err_r    <= err_nxt;
      cx_r     <= cx_nxt;
      cy_r     <= cy_nxt;
      color_r  <= color_nxt;
    end
  end

endmodule

### sv/csg_queue.sv
// Two-entry job queue between front and back end.
// Depends on csg_pkg for the job type.
module csg_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  csg_pkg::job_t push_data,
  input  logic          pop,
  output logic          full,
  output logic          head_valid,
  output csg_pkg::job_t head_data
);

  logic [1:0]    count_r, count_nxt;
  csg_pkg::job_t head_r, head_nxt;
  csg_pkg::job_t tail_r, tail_nxt;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_data  = head_r;

  // Occupancy and entry moves
  always_comb begin
    count_nxt = count_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    unique case (count_r)
      2'd0: begin
        if (push) begin
          head_nxt  = push_data;
          count_nxt = 2'd1;
        end
      end
      2'd1: begin
        if (push && pop) begin
          head_nxt = push_data;
        end else if (push) begin
          tail_nxt  = push_data;
          count_nxt = 2'd2;
        end else if (pop) begin
          count_nxt = 2'd0;
        end
      end
      2'd2: begin
        if (pop) begin
          head_nxt  = tail_r;
          count_nxt = 2'd1;
        end
      end
      default: count_nxt = 2'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Entries carry payload only
  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

endmodule

### sv/csg_back.sv
// Back end: expands one job into two or four spans, one per cycle
// while out_stall is low, through a registered output stage. Depends on csg_pkg.
module csg_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           job_valid,
  input  csg_pkg::job_t                  job,
  output logic                           job_pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [csg_pkg::COORD_W-1:0] out_span_row,
  output logic signed [csg_pkg::COORD_W-1:0] out_span_left,
  output logic signed [csg_pkg::COORD_W-1:0] out_span_right,
  output logic [csg_pkg::COLOR_W-1:0]    out_span_color,
  output logic                           out_last_of_step,
  output logic                           out_circle_done
);

  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_LAST   = 2'd3;

  logic [1:0]                          phase_r;
  logic                                out_valid_r;
  csg_pkg::coord_t                     row_r, left_r, right_r;
  logic [csg_pkg::COLOR_W-1:0]         color_r;
  logic                                last_r, done_r;

  logic                                load, last;
  csg_pkg::coord_t                     a, b;
  logic signed [csg_pkg::COORD_W:0]    cx_e, cy_e, a_e, b_e;
  logic signed [csg_pkg::COORD_W:0]    row_w, left_w, right_w;

  // Output register free when empty or being taken
  assign load    = job_valid && (!out_valid_r || !out_stall);
  assign last    = ((phase_r == PH_SECOND) && job.pair_eq) || (phase_r == PH_LAST);
  assign job_pop = load && last;

  // Span geometry: phases 0/1 use (y,x), phases 2/3 use (x,y)
  always_comb begin
    a       = phase_r[1] ? job.x : job.y;
    b       = phase_r[1] ? job.y : job.x;
    cx_e    = $signed({3'b000, job.cx});
    cy_e    = $signed({3'b000, job.cy});
    a_e     = {a[csg_pkg::COORD_W-1], a};
    b_e     = {b[csg_pkg::COORD_W-1], b};
    row_w   = phase_r[0] ? (cy_e - a_e) : (cy_e + a_e);
    left_w  = cx_e - b_e;
    right_w = cx_e + b_e;
  end

  // Phase counter and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        phase_r     <= last ? PH_FIRST : (phase_r + 2'd1);
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      row_r   <= csg_pkg::sat_coord(row_w);
      left_r  <= csg_pkg::sat_coord(left_w);
      right_r <= csg_pkg::sat_coord(right_w);
      color_r <= job.color;
      last_r  <= last;
      done_r  <= last && job.done;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_span_row     = row_r;
  assign out_span_left    = left_r;
  assign out_span_right   = right_r;
  assign out_span_color   = color_r;
  assign out_last_of_step = last_r;
  assign out_circle_done  = done_r;

`ifndef SYNTHESIS
  // End of circle only on the final span of a step
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && done_r |-> last_r)
    else $error("circle_done without last_of_step");

  // Mid-job phase needs a job at the queue head
  a_phase_has_job: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_FIRST) |-> job_valid)
    else $error("phase advanced with no job");

  // A job leaves only after its final span
  a_pop_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> ((phase_r == PH_SECOND) && job.pair_eq) || (phase_r == PH_LAST))
    else $error("job popped early");

  // Equal offsets never reach the third span
  a_pair_two: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid && job.pair_eq |-> !phase_r[1])
    else $error("extra spans for x equal y");
`endif

endmodule

### sv/circle_span_generator.sv
// Filled circle span generator: accepts start and advance items and emits
// one horizontal span per cycle while the output is not stalled. A start
// item loads the circle state and emits nothing. An advance item yields
// four spans, or two when the offsets are equal; the span expander in the
// back end, which drives one span per cycle, sets the output rate. A
// two-entry job queue lets the front take up to two advances ahead of the
// output. Negative radius or advances after the end emit nothing.
// Depends on csg_pkg, csg_front, csg_queue and csg_back.
module circle_span_generator #(
  parameter int unsigned MAX_DIM = 512
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_command,
  input  logic [csg_pkg::CENTER_W-1:0]       in_center_x,
  input  logic [csg_pkg::CENTER_W-1:0]       in_center_y,
  input  logic signed [csg_pkg::COORD_W-1:0] in_radius,
  input  logic [csg_pkg::COLOR_W-1:0]        in_color,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [csg_pkg::COORD_W-1:0] out_span_row,
  output logic signed [csg_pkg::COORD_W-1:0] out_span_left,
  output logic signed [csg_pkg::COORD_W-1:0] out_span_right,
  output logic [csg_pkg::COLOR_W-1:0]        out_span_color,
  output logic                               out_last_of_step,
  output logic                               out_circle_done
);

  logic          job_push, job_pop, q_full, q_valid;
  csg_pkg::job_t push_data, head_data;

  assign in_stall = q_full;

  // Item intake and midpoint state
  csg_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_command  (in_command),
    .in_center_x (in_center_x),
    .in_center_y (in_center_y),
    .in_radius   (in_radius),
    .in_color    (in_color),
    .job_push    (job_push),
    .job_data    (push_data)
  );

  // Job queue
  csg_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (job_push),
    .push_data  (push_data),
    .pop        (job_pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head_data  (head_data)
  );

  // Span expansion and output register
  csg_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .job_valid        (q_valid),
    .job              (head_data),
    .job_pop          (job_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_span_row     (out_span_row),
    .out_span_left    (out_span_left),
    .out_span_right   (out_span_right),
    .out_span_color   (out_span_color),
    .out_last_of_step (out_last_of_step),
    .out_circle_done  (out_circle_done)
  );

endmodule
